/* src/hrf_pkg.sv */
package hrf_pkg;

	localparam int LENGTH_BITS_DEF = 32;
	localparam int OUT_LEN_BITS    = 32;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [4:0] GET_LEN  = 5'd4;
	localparam logic [4:0] POST_LEN = 5'd5;
	localparam logic [4:0] KEY_LEN  = 5'd14;
	localparam logic [4:0] COL_MAX  = 5'd31;

	typedef enum logic [2:0] {
		PH_WAIT = 3'd0,
		PH_REQ  = 3'd1,
		PH_HDR  = 3'd2,
		PH_BODY = 3'd3,
		PH_ERR  = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		KIND_REQ  = 3'd0,
		KIND_HDR  = 3'd1,
		KIND_TERM = 3'd2,
		KIND_BODY = 3'd3,
		KIND_DROP = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_METHOD   = 3'd1,
		ERR_NO_LEN   = 3'd2,
		ERR_NO_COLON = 3'd3,
		ERR_BAD_LEN  = 3'd4
	} err_t;

	// framer control state (everything but the wide counters)
	typedef struct packed {
		phase_t      phase;
		logic        prev_cr;
		logic [4:0]  col;
		logic [1:0]  mm;       // bit 0 GET candidate, bit 1 POST candidate
		logic        key;
		logic        colon;
		logic        vstart;
		logic        lfound;
		logic        lbad;
		err_t        err;
	} ctl_t;

	localparam ctl_t CTL_RESET = '{
		phase:   PH_WAIT,
		prev_cr: 1'b0,
		col:     5'd0,
		mm:      2'b11,
		key:     1'b1,
		colon:   1'b0,
		vstart:  1'b0,
		lfound:  1'b0,
		lbad:    1'b0,
		err:     ERR_NONE
	};

	// per-word result flags
	typedef struct packed {
		kind_t kind;
		logic  hd;
		logic  me;
		err_t  err;
		logic  post;
	} res_t;

	function automatic logic [7:0] get_char(input logic [1:0] i);
		case (i)
			2'd0:    get_char = 8'h47; // G
			2'd1:    get_char = 8'h45; // E
			2'd2:    get_char = 8'h54; // T
			default: get_char = CH_SPACE;
		endcase
	endfunction

	function automatic logic [7:0] post_char(input logic [2:0] i);
		case (i)
			3'd0:    post_char = 8'h50; // P
			3'd1:    post_char = 8'h4F; // O
			3'd2:    post_char = 8'h53; // S
			3'd3:    post_char = 8'h54; // T
			3'd4:    post_char = CH_SPACE;
			default: post_char = 8'h00;
		endcase
	endfunction

	// "Content-Length"
	function automatic logic [7:0] key_char(input logic [3:0] i);
		case (i)
			4'd0:    key_char = 8'h43;
			4'd1:    key_char = 8'h6F;
			4'd2:    key_char = 8'h6E;
			4'd3:    key_char = 8'h74;
			4'd4:    key_char = 8'h65;
			4'd5:    key_char = 8'h6E;
			4'd6:    key_char = 8'h74;
			4'd7:    key_char = 8'h2D;
			4'd8:    key_char = 8'h4C;
			4'd9:    key_char = 8'h65;
			4'd10:   key_char = 8'h6E;
			4'd11:   key_char = 8'h67;
			4'd12:   key_char = 8'h74;
			4'd13:   key_char = 8'h68;
			default: key_char = 8'h00;
		endcase
	endfunction

endpackage

/* src/hrf_step.sv */
module hrf_step #(
	parameter int LENGTH_BITS = hrf_pkg::LENGTH_BITS_DEF
) (
	input  logic [7:0]                 data_byte,
	input  hrf_pkg::ctl_t              ctl_cur,
	input  logic [LENGTH_BITS-1:0]     acc_cur,
	input  logic [LENGTH_BITS-1:0]     rem_cur,
	output hrf_pkg::ctl_t              ctl_nxt,
	output logic [LENGTH_BITS-1:0]     acc_nxt,
	output logic [LENGTH_BITS-1:0]     rem_nxt,
	output hrf_pkg::res_t              res,
	output logic [hrf_pkg::OUT_LEN_BITS-1:0] blen
);

	typedef struct packed {
		hrf_pkg::ctl_t          ctl;
		logic [LENGTH_BITS-1:0] acc;
	} work_t;

	function automatic work_t clear_line(input work_t w);
		work_t r;
		r = w;
		r.ctl.col    = '0;
		r.ctl.key    = 1'b1;
		r.ctl.colon  = 1'b0;
		r.ctl.vstart = 1'b0;
		return r;
	endfunction

	function automatic work_t clear_request(input work_t w);
		work_t r;
		r = clear_line(w);
		r.ctl.mm     = 2'b11;
		r.acc        = '0;
		r.ctl.lfound = 1'b0;
		r.ctl.lbad   = 1'b0;
		return r;
	endfunction

	// one byte of line content (request line or header line)
	function automatic work_t content(input work_t w, input logic [7:0] c);
		work_t                  r;
		logic [4:0]             col;
		logic [7:0]             dig;
		logic [LENGTH_BITS+3:0] prod;
		r    = w;
		col  = w.ctl.col;
		dig  = c - hrf_pkg::CH_ZERO;
		prod = ({4'b0, w.acc} << 3) + ({4'b0, w.acc} << 1)
			+ {{LENGTH_BITS{1'b0}}, dig[3:0]};
		if (r.ctl.phase == hrf_pkg::PH_WAIT)
			r.ctl.phase = hrf_pkg::PH_REQ;
		if (r.ctl.phase == hrf_pkg::PH_REQ) begin
			if (col < hrf_pkg::GET_LEN && c != hrf_pkg::get_char(col[1:0]))
				r.ctl.mm[0] = 1'b0;
			if (col < hrf_pkg::POST_LEN && c != hrf_pkg::post_char(col[2:0]))
				r.ctl.mm[1] = 1'b0;
		end else if (!r.ctl.colon) begin
			if (c == hrf_pkg::CH_COLON) begin
				r.ctl.colon = 1'b1;
				if (r.ctl.key && col == hrf_pkg::KEY_LEN && !r.ctl.lfound) begin
					r.ctl.lfound = 1'b1;
					r.acc        = '0;
				end else begin
					r.ctl.key = 1'b0;
				end
			end else if (col >= hrf_pkg::KEY_LEN || c != hrf_pkg::key_char(col[3:0])) begin
				r.ctl.key = 1'b0;
			end
		end else if (r.ctl.key) begin
			if (r.ctl.vstart || c != hrf_pkg::CH_SPACE) begin
				r.ctl.vstart = 1'b1;
				if (c >= hrf_pkg::CH_ZERO && c <= hrf_pkg::CH_NINE) begin
					// acc*10+d overflows exactly when the top bits are nonzero
					if (prod[LENGTH_BITS+3:LENGTH_BITS] != 4'd0)
						r.ctl.lbad = 1'b1;
					else
						r.acc = prod[LENGTH_BITS-1:0];
				end else begin
					r.ctl.lbad = 1'b1;
				end
			end
		end
		if (col != hrf_pkg::COL_MAX)
			r.ctl.col = col + 5'd1;
		return r;
	endfunction

	work_t                              w;
	logic [LENGTH_BITS+hrf_pkg::OUT_LEN_BITS-1:0] blen_ext;

	always_comb begin
		w        = '{ctl: ctl_cur, acc: acc_cur};
		rem_nxt  = rem_cur;
		res      = '{kind: hrf_pkg::KIND_REQ, hd: 1'b0, me: 1'b0,
			err: hrf_pkg::ERR_NONE, post: 1'b0};
		blen_ext = '0;
		case (ctl_cur.phase)
			hrf_pkg::PH_ERR: begin
				res.kind = hrf_pkg::KIND_DROP;
			end
			hrf_pkg::PH_BODY: begin
				res.kind = hrf_pkg::KIND_BODY;
				res.post = w.ctl.mm[1];
				if (rem_cur[LENGTH_BITS-1:1] == '0) begin
					res.me      = 1'b1;
					w           = clear_request(w);
					w.ctl.phase = hrf_pkg::PH_WAIT;
					rem_nxt     = '0;
				end else begin
					rem_nxt = rem_cur - 1'b1;
				end
			end
			default: begin
				// a CR not followed by LF was line content after all
				if (w.ctl.prev_cr && data_byte != hrf_pkg::CH_LF) begin
					w.ctl.prev_cr = 1'b0;
					w             = content(w, hrf_pkg::CH_CR);
				end
				if (data_byte == hrf_pkg::CH_CR) begin
					w.ctl.prev_cr = 1'b1;
					res.kind      = hrf_pkg::KIND_TERM;
				end else if (data_byte == hrf_pkg::CH_LF && w.ctl.prev_cr) begin
					w.ctl.prev_cr = 1'b0;
					res.kind      = hrf_pkg::KIND_TERM;
					if (w.ctl.phase == hrf_pkg::PH_REQ) begin
						if (w.ctl.col < hrf_pkg::GET_LEN)
							w.ctl.mm[0] = 1'b0;
						if (w.ctl.col < hrf_pkg::POST_LEN)
							w.ctl.mm[1] = 1'b0;
						w.ctl.phase = hrf_pkg::PH_HDR;
						w           = clear_line(w);
					end else if (w.ctl.phase == hrf_pkg::PH_HDR) begin
						if (w.ctl.col == '0) begin
							// blank line: end of headers
							if (w.ctl.mm[0]) begin
								res.hd      = 1'b1;
								res.me      = 1'b1;
								w           = clear_request(w);
								w.ctl.phase = hrf_pkg::PH_WAIT;
								rem_nxt     = '0;
							end else if (w.ctl.mm[1]) begin
								if (!w.ctl.lfound) begin
									w.ctl.err   = hrf_pkg::ERR_NO_LEN;
									w.ctl.phase = hrf_pkg::PH_ERR;
								end else if (w.ctl.lbad) begin
									w.ctl.err   = hrf_pkg::ERR_BAD_LEN;
									w.ctl.phase = hrf_pkg::PH_ERR;
								end else begin
									res.hd   = 1'b1;
									res.post = 1'b1;
									blen_ext = {{hrf_pkg::OUT_LEN_BITS{1'b0}}, w.acc};
									if (w.acc == '0) begin
										res.me      = 1'b1;
										w           = clear_request(w);
										w.ctl.phase = hrf_pkg::PH_WAIT;
										rem_nxt     = '0;
									end else begin
										rem_nxt     = w.acc;
										w.ctl.phase = hrf_pkg::PH_BODY;
										w           = clear_line(w);
									end
								end
							end else begin
								w.ctl.err   = hrf_pkg::ERR_METHOD;
								w.ctl.phase = hrf_pkg::PH_ERR;
							end
						end else begin
							if (!w.ctl.colon) begin
								w.ctl.err   = hrf_pkg::ERR_NO_COLON;
								w.ctl.phase = hrf_pkg::PH_ERR;
							end else if (w.ctl.key && !w.ctl.vstart) begin
								w.ctl.lbad = 1'b1;
							end
							w = clear_line(w);
						end
					end
				end else begin
					w        = content(w, data_byte);
					res.kind = (w.ctl.phase == hrf_pkg::PH_REQ) ?
						hrf_pkg::KIND_REQ : hrf_pkg::KIND_HDR;
					if (w.ctl.phase == hrf_pkg::PH_HDR)
						res.post = w.ctl.mm[1];
				end
				if (res.kind == hrf_pkg::KIND_TERM && w.ctl.phase == hrf_pkg::PH_HDR
					&& !res.hd)
					res.post = w.ctl.mm[1];
			end
		endcase
		res.err = w.ctl.err;
		ctl_nxt = w.ctl;
		acc_nxt = w.acc;
		blen    = blen_ext[hrf_pkg::OUT_LEN_BITS-1:0];
	end

endmodule

/* src/http_request_framer_core.sv */
// Channel  Handshake            Payload
// -------  -------------------  ----------------------------------------------
// in       in_valid / in_ready  data_byte
// out      out_valid/out_ready  byte_kind, headers_done, message_end,
//                               error_code, body_length, is_post
//
// One result word per input word, through the input register and then the
// result register; one word per clock sustained while out_ready stays high.
// The framer state (line scan, length parse, body count) updates in the
// same cycle the staged byte moves into the result register.
// Reset clears the framer to "waiting for request line" and empties both
// stages. A stalled output holds both stages; in_ready drops only when
// both are full and out_ready is low.
module http_request_framer_core #(
	parameter int LENGTH_BITS = hrf_pkg::LENGTH_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        data_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [2:0]                        byte_kind,
	output logic                              headers_done,
	output logic                              message_end,
	output logic [2:0]                        error_code,
	output logic [hrf_pkg::OUT_LEN_BITS-1:0]  body_length,
	output logic                              is_post
);

	// input stage
	logic                               valid_s1;
	logic [7:0]                         data_s1;

	// framer state
	hrf_pkg::ctl_t                      ctl_q;
	logic [LENGTH_BITS-1:0]             acc_q;
	logic [LENGTH_BITS-1:0]             rem_q;

	// next state and result from the step logic
	hrf_pkg::ctl_t                      ctl_d;
	logic [LENGTH_BITS-1:0]             acc_d;
	logic [LENGTH_BITS-1:0]             rem_d;
	hrf_pkg::res_t                      res_d;
	logic [hrf_pkg::OUT_LEN_BITS-1:0]   blen_d;

	// result register
	logic                               out_valid_q;
	hrf_pkg::res_t                      res_q;
	logic [hrf_pkg::OUT_LEN_BITS-1:0]   blen_q;

	logic                               advance;

	// staged byte moves on when the result slot is free or being emptied
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || !out_valid_q || out_ready;

	hrf_step #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_step (
		.data_byte (data_s1),
		.ctl_cur   (ctl_q),
		.acc_cur   (acc_q),
		.rem_cur   (rem_q),
		.ctl_nxt   (ctl_d),
		.acc_nxt   (acc_d),
		.rem_nxt   (rem_d),
		.res       (res_d),
		.blen      (blen_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			ctl_q       <= hrf_pkg::CTL_RESET;
			acc_q       <= '0;
			rem_q       <= '0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance) begin
				out_valid_q <= 1'b1;
				ctl_q       <= ctl_d;
				acc_q       <= acc_d;
				rem_q       <= rem_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			data_s1 <= data_byte;
		if (advance) begin
			res_q  <= res_d;
			blen_q <= blen_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign byte_kind    = res_q.kind;
	assign headers_done = res_q.hd;
	assign message_end  = res_q.me;
	assign error_code   = res_q.err;
	assign body_length  = blen_q;
	assign is_post      = res_q.post;

endmodule

/* tb/sv/http_framer_checker.sv */
`timescale 1ns / 1ps

module http_framer_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [2:0]  byte_kind,
	input  logic        headers_done,
	input  logic        message_end,
	input  logic [2:0]  error_code,
	input  logic [31:0] body_length,
	input  logic        is_post,
	output int          fail_count,
	output int          pending
);

	localparam int          LEN_W   = hrf_pkg::LENGTH_BITS_DEF;
	localparam logic [63:0] LEN_MAX = (64'd1 << LEN_W) - 64'd1;

	localparam logic [8*4-1:0]  GET_TXT  = "GET ";
	localparam logic [8*5-1:0]  POST_TXT = "POST ";
	localparam logic [8*14-1:0] KEY_TXT  = "Content-Length";

	typedef struct packed {
		hrf_pkg::kind_t kind;
		logic           hd;
		logic           me;
		hrf_pkg::err_t  err;
		logic [31:0]    blen;
		logic           post;
	} framer_word_t;

	// framer state as the block should hold it
	hrf_pkg::phase_t ph;
	logic            cr_pend;
	logic [4:0]      col;
	logic [1:0]      meth;      // bit 0 GET still possible, bit 1 POST
	logic            key_ok;
	logic            colon_hit;
	logic            val_begun;
	logic [63:0]     len_acc;
	logic            len_seen;
	logic            len_err;
	logic [63:0]     body_left;
	hrf_pkg::err_t   err_hold;

	framer_word_t expected_words[$];
	int           mismatches = 0;
	int           outstanding = 0;

	assign fail_count = mismatches;
	assign pending    = outstanding;

	function automatic void clear_line_scan();
		col       = '0;
		key_ok    = 1'b1;
		colon_hit = 1'b0;
		val_begun = 1'b0;
	endfunction

	function automatic void clear_request_scan();
		clear_line_scan();
		meth      = 2'b11;
		len_acc   = '0;
		len_seen  = 1'b0;
		len_err   = 1'b0;
		body_left = '0;
	endfunction

	// one byte of line content: method match, key match, length digits
	function automatic void scan_char(input logic [7:0] c);
		logic [4:0]  at;
		logic [63:0] d;
		at = col;
		if (ph == hrf_pkg::PH_WAIT)
			ph = hrf_pkg::PH_REQ;
		if (ph == hrf_pkg::PH_REQ) begin
			if (at < hrf_pkg::GET_LEN
				&& c != GET_TXT[8*(hrf_pkg::GET_LEN-1-at) +: 8])
				meth[0] = 1'b0;
			if (at < hrf_pkg::POST_LEN
				&& c != POST_TXT[8*(hrf_pkg::POST_LEN-1-at) +: 8])
				meth[1] = 1'b0;
		end else if (!colon_hit) begin
			if (c == hrf_pkg::CH_COLON) begin
				colon_hit = 1'b1;
				if (key_ok && at == hrf_pkg::KEY_LEN && !len_seen) begin
					len_seen = 1'b1;
					len_acc  = '0;
				end else begin
					key_ok = 1'b0;
				end
			end else if (at >= hrf_pkg::KEY_LEN
				|| c != KEY_TXT[8*(hrf_pkg::KEY_LEN-1-at) +: 8]) begin
				key_ok = 1'b0;
			end
		end else if (key_ok && !(!val_begun && c == hrf_pkg::CH_SPACE)) begin
			val_begun = 1'b1;
			if (c >= hrf_pkg::CH_ZERO && c <= hrf_pkg::CH_NINE) begin
				d = 64'(c - hrf_pkg::CH_ZERO);
				if (len_acc > (LEN_MAX - d) / 64'd10)
					len_err = 1'b1;
				else
					len_acc = len_acc * 64'd10 + d;
			end else begin
				len_err = 1'b1;
			end
		end
		if (col < hrf_pkg::COL_MAX)
			col++;
	endfunction

	function automatic framer_word_t frame_byte(input logic [7:0] c);
		framer_word_t w;
		w      = '0;
		w.kind = hrf_pkg::KIND_REQ;
		if (ph == hrf_pkg::PH_ERR) begin
			w.kind = hrf_pkg::KIND_DROP;
		end else if (ph == hrf_pkg::PH_BODY) begin
			w.kind = hrf_pkg::KIND_BODY;
			w.post = meth[1];
			if (body_left <= 64'd1) begin
				w.me = 1'b1;
				ph   = hrf_pkg::PH_WAIT;
				clear_request_scan();
			end else begin
				body_left--;
			end
		end else begin
			// a CR not followed by LF was line content after all
			if (cr_pend && c != hrf_pkg::CH_LF) begin
				cr_pend = 1'b0;
				scan_char(hrf_pkg::CH_CR);
			end
			if (c == hrf_pkg::CH_CR) begin
				cr_pend = 1'b1;
				w.kind  = hrf_pkg::KIND_TERM;
			end else if (c == hrf_pkg::CH_LF && cr_pend) begin
				cr_pend = 1'b0;
				w.kind  = hrf_pkg::KIND_TERM;
				if (ph == hrf_pkg::PH_REQ) begin
					if (col < hrf_pkg::GET_LEN)
						meth[0] = 1'b0;
					if (col < hrf_pkg::POST_LEN)
						meth[1] = 1'b0;
					ph = hrf_pkg::PH_HDR;
					clear_line_scan();
				end else if (ph == hrf_pkg::PH_HDR) begin
					if (col == 0) begin
						if (meth[0]) begin
							w.hd = 1'b1;
							w.me = 1'b1;
							ph   = hrf_pkg::PH_WAIT;
							clear_request_scan();
						end else if (meth[1]) begin
							if (!len_seen) begin
								err_hold = hrf_pkg::ERR_NO_LEN;
								ph       = hrf_pkg::PH_ERR;
							end else if (len_err) begin
								err_hold = hrf_pkg::ERR_BAD_LEN;
								ph       = hrf_pkg::PH_ERR;
							end else begin
								w.hd   = 1'b1;
								w.post = 1'b1;
								w.blen = len_acc[31:0];
								if (len_acc == 0) begin
									w.me = 1'b1;
									ph   = hrf_pkg::PH_WAIT;
									clear_request_scan();
								end else begin
									body_left = len_acc;
									ph        = hrf_pkg::PH_BODY;
									clear_line_scan();
								end
							end
						end else begin
							err_hold = hrf_pkg::ERR_METHOD;
							ph       = hrf_pkg::PH_ERR;
						end
					end else begin
						if (!colon_hit) begin
							err_hold = hrf_pkg::ERR_NO_COLON;
							ph       = hrf_pkg::PH_ERR;
						end else if (key_ok && !val_begun) begin
							len_err = 1'b1;
						end
						clear_line_scan();
						if (ph == hrf_pkg::PH_HDR)
							w.post = meth[1];
					end
				end
			end else begin
				scan_char(c);
				w.kind = (ph == hrf_pkg::PH_REQ) ? hrf_pkg::KIND_REQ : hrf_pkg::KIND_HDR;
				if (ph == hrf_pkg::PH_HDR)
					w.post = meth[1];
			end
			if (w.kind == hrf_pkg::KIND_TERM && ph == hrf_pkg::PH_HDR && !w.hd)
				w.post = meth[1];
		end
		w.err = err_hold;
		return w;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		framer_word_t want;
		if (!arst_n) begin
			ph       = hrf_pkg::PH_WAIT;
			cr_pend  = 1'b0;
			err_hold = hrf_pkg::ERR_NONE;
			clear_request_scan();
			expected_words.delete();
		end else begin
			// check first: a word leaving now can never be the one entering now
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word, expected none, got kind %0d",
						$time, byte_kind);
					mismatches++;
				end else begin
					want = expected_words.pop_front();
					check_field("byte_kind", 32'(want.kind), 32'(byte_kind));
					check_field("headers_done", 32'(want.hd), 32'(headers_done));
					check_field("message_end", 32'(want.me), 32'(message_end));
					check_field("error_code", 32'(want.err), 32'(error_code));
					check_field("body_length", want.blen, body_length);
					check_field("is_post", 32'(want.post), 32'(is_post));
				end
			end
			if (in_valid && in_ready)
				expected_words.push_back(frame_byte(data_byte));
		end
		outstanding = expected_words.size();
	end

endmodule

/* tb/sv/tb_http_request_framer_core.sv */
`timescale 1ns / 1ps

module tb_http_request_framer_core;

	// cycles with no word moving on either side before we give up
	localparam int STALL_LIMIT = 500;
	// bytes of random requests before the closing error scenario
	localparam int RANDOM_BYTES = 1000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  byte_kind;
	logic        headers_done;
	logic        message_end;
	logic [2:0]  error_code;
	logic [31:0] body_length;
	logic        is_post;

	int fail_count;
	int pending;

	// bytes queued for the input side, and how many were accepted so far
	logic [7:0] stream_q[$];
	int         sent = 0;
	int         idle_cycles = 0;
	// while set, that side runs back to back with no gaps
	bit         steady_in = 1'b0;
	bit         steady_out = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	http_request_framer_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.byte_kind    (byte_kind),
		.headers_done (headers_done),
		.message_end  (message_end),
		.error_code   (error_code),
		.body_length  (body_length),
		.is_post      (is_post)
	);

	http_framer_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.byte_kind    (byte_kind),
		.headers_done (headers_done),
		.message_end  (message_end),
		.error_code   (error_code),
		.body_length  (body_length),
		.is_post      (is_post),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// ---------------------------------------------------------------
	// Stream building. Requests are assembled as bytes first and then
	// pushed through the input channel one word at a time.
	// ---------------------------------------------------------------

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			stream_q.push_back(s[i]);
	endtask

	task automatic put_crlf();
		stream_q.push_back(hrf_pkg::CH_CR);
		stream_q.push_back(hrf_pkg::CH_LF);
	endtask

	// Random line content. An LF right after a content CR would end the
	// line early, so that pair is never made. Header keys get no colon.
	task automatic put_noise(input int n, input bit allow_colon);
		logic [7:0] b;
		for (int i = 0; i < n; i++) begin
			b = 8'($urandom_range(0, 255));
			if (stream_q.size() != 0 && stream_q[$] == hrf_pkg::CH_CR
				&& b == hrf_pkg::CH_LF)
				b = 8'h41;
			if (!allow_colon && b == hrf_pkg::CH_COLON)
				b = 8'h3B;
			stream_q.push_back(b);
		end
	endtask

	// One well-formed request with random content. Never raises an error:
	// POST always carries a good first length header, GET may carry junk.
	task automatic put_request();
		int nhdr;
		int lpos;
		int blen;
		bit post;
		// empty lines before the request line are skipped by the framer
		repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0)
			put_crlf();
		post = 1'($urandom_range(0, 1));
		put_text(post ? "POST " : "GET ");
		// sometimes past 31 columns to hit the column counter saturation
		put_noise(($urandom_range(0, 5) == 0) ? $urandom_range(30, 40)
			: $urandom_range(0, 12), 1'b1);
		put_crlf();
		nhdr = $urandom_range(0, 4);
		lpos = $urandom_range(0, nhdr);
		blen = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
		for (int h = 0; h <= nhdr; h++) begin
			if (h == lpos && post) begin
				// leading spaces and leading zeros are both legal
				put_text("Content-Length:");
				repeat ($urandom_range(0, 3)) put_text(" ");
				repeat ($urandom_range(0, 2)) put_text("0");
				put_text($sformatf("%0d", blen));
			end else begin
				case ($urandom_range(0, 6))
					0: put_text("Content-Lengt:");
					1: put_text("content-length:");
					2: put_text("Content-LengthX:");
					3: put_text("Content-Length :");
					// length header on GET, or a later one on POST: never used
					4: begin
						if (post && h < lpos)
							put_text("Content-Lengt:");
						else
							put_text("Content-Length:");
					end
					default: begin
						put_noise($urandom_range(0, 20), 1'b0);
						put_text(":");
					end
				endcase
				put_noise(($urandom_range(0, 7) == 0) ? $urandom_range(25, 40)
					: $urandom_range(0, 16), 1'b1);
			end
			put_crlf();
		end
		// a later length header is ignored whatever it holds
		if ($urandom_range(0, 4) == 0) begin
			put_text("Content-Length: ");
			put_noise(3, 1'b1);
			put_crlf();
		end
		put_crlf();
		if (post)
			put_noise(blen, 1'b1);
	endtask

	// drives each byte, holding it until the block takes it
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if ($urandom_range(0, 40) == 0)
			steady_in = !steady_in;
		gap = steady_in ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	task automatic flush_stream();
		while (stream_q.size() != 0)
			send_byte(stream_q.pop_front());
	endtask

	// ---------------------------------------------------------------
	// Output side: a random stall before taking each result word.
	// ---------------------------------------------------------------
	initial begin
		int stall;
		forever begin
			if ($urandom_range(0, 40) == 0)
				steady_out = !steady_out;
			stall = steady_out ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	// Watchdog: counts cycles in which no word moves on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Main sequence. Errors latch until reset and reset happens only
	// once, so the single error scenario of a run comes last.
	// ---------------------------------------------------------------
	initial begin
		string s;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// skipped empty line, then GET whose request line holds a lone LF,
		// a lone CR and a zero byte
		put_crlf();
		put_text("GET ");
		stream_q.push_back(hrf_pkg::CH_LF);
		stream_q.push_back(hrf_pkg::CH_CR);
		stream_q.push_back(8'h00);
		put_crlf();
		put_crlf();
		// minimal POST with a one byte body of all ones
		put_text("POST ");
		put_crlf();
		put_text("Content-Length:1");
		put_crlf();
		put_crlf();
		stream_q.push_back(8'hFF);
		flush_stream();

		while (sent < RANDOM_BYTES) begin
			put_request();
			flush_stream();
		end

		// closing scenario: one of the error kinds, or the largest length
		case ($urandom_range(0, 4))
			0: begin
				// bad method: short line, unknown verb, or a CR before it
				case ($urandom_range(0, 2))
					0: put_text("GET");
					1: put_text("PUT /x");
					default: begin
						stream_q.push_back(hrf_pkg::CH_CR);
						put_text("GET /");
					end
				endcase
				put_crlf();
				put_crlf();
			end
			1: begin
				// POST with no length header
				put_text("POST /");
				put_crlf();
				put_text("Host: x");
				put_crlf();
				put_crlf();
			end
			2: begin
				// header line without a colon
				put_text("GET /");
				put_crlf();
				put_text("NoColonHere");
				put_crlf();
			end
			3: begin
				// bad length: overflow, stray letter, empty, trailing space
				case ($urandom_range(0, 3))
					0: s = " 4294967296";
					1: s = " 12a";
					2: s = "   ";
					default: s = "7 ";
				endcase
				put_text("POST /");
				put_crlf();
				put_text({"Content-Length:", s});
				put_crlf();
				put_crlf();
			end
			default: begin
				// largest length that fits; the body never completes
				put_text("POST /");
				put_crlf();
				put_text("Content-Length: 4294967295");
				put_crlf();
				put_crlf();
			end
		endcase
		put_noise(20, 1'b1);
		flush_stream();
		in_valid <= 1'b0;

		// drain, then leave room for any stray word
		do @(posedge clk); while (pending != 0);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
